// ===== src/km2d_pkg.sv =====
package km2d_pkg;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_END      = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DM_MANHATTAN = 2'd0,
    DM_EUCLID    = 2'd1,
    DM_SQUARED   = 2'd2,
    DM_ZERO      = 2'd3
  } dmode_t;

  localparam logic [1:0] CFG_NUM_CENTROIDS = 2'd0;
  localparam logic [1:0] CFG_DIST_MODE     = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD     = 2'd2;

  localparam int CFG_DATA_W = 48;
  localparam int COORD_W    = 32;
  localparam int ERR_W      = 48;
  localparam int KEY_W      = 66;

endpackage

// ===== src/km2d_if.sv =====
interface km2d_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  centroid_slot;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  modport source (output valid, operation, centroid_slot, coord_x, coord_y, input ready);
  modport sink   (input valid, operation, centroid_slot, coord_x, coord_y, output ready);
endinterface

interface km2d_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  nearest_index;
  logic [3:0]  centroid_id;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic [47:0] movement_total;
  logic        converged;
  logic        last;
  modport source (output valid, nearest_index, centroid_id, new_x, new_y, movement_total,
                  converged, last, input ready);
  modport sink   (input valid, nearest_index, centroid_id, new_x, new_y, movement_total,
                  converged, last, output ready);
endinterface

// ===== src/kmeans_2d_iteration_unit.sv =====
// k-means 2-D iteration unit, one Lloyd step over signed Q16.16 points.
// Channels: in_ch (sink) takes words of operation, slot and coordinates;
// out_ch (source) gives result words; cfg_we/cfg_index/cfg_data write the
// three registers (centroid count, distance mode, error threshold).
// A load word writes a centroid slot and gives nothing.
// A classify word walks the centroids in use through one shared distance
// datapath: per centroid load, difference, two squares and compare, plus
// the bit-pair square root in Euclidean mode; then an accumulate step and
// one result word with last set.
// An end word runs, per member centroid, two 52-step serial divisions and
// a movement distance, then streams one word per centroid in use, the
// last flagged, and clears the counts of all MAX_CENTROIDS slots.
// Reset clears control state and member counts, sets one centroid,
// Euclidean mode, zero threshold; sums are zeroed lazily at count zero.
// in_ch.ready is high only in the idle state; while the receiver stalls the
// result register holds and the sequencer waits.
module kmeans_2d_iteration_unit #(
  parameter int MAX_CENTROIDS = 16,
  parameter int COUNT_BITS    = 20
) (
  input  logic        clk,
  input  logic        rst,
  km2d_in_if.sink     in_ch,
  km2d_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [km2d_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int IDX_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int N_W   = $clog2(MAX_CENTROIDS + 1);
  localparam int SUM_W = 32 + COUNT_BITS;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DIFF  = 14'b00000000000010,
    S_SQ    = 14'b00000000000100,
    S_SUM   = 14'b00000000001000,
    S_SQRT  = 14'b00000000010000,
    S_CMP   = 14'b00000000100000,
    S_ACC   = 14'b00000001000000,
    S_POUT  = 14'b00000010000000,
    S_DIVX  = 14'b00000100000000,
    S_DIVY  = 14'b00001000000000,
    S_MOVE  = 14'b00010000000000,
    S_EOUT  = 14'b00100000000000,
    S_CLR   = 14'b01000000000000,
    S_DIVW  = 14'b10000000000000
  } state_t;

  state_t state;

  // configuration
  logic [4:0]  num_centroids;
  logic [1:0]  distance_mode;
  logic [47:0] error_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_centroids   <= 5'd1;
      distance_mode   <= km2d_pkg::DM_EUCLID;
      error_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        km2d_pkg::CFG_NUM_CENTROIDS: num_centroids <= cfg_data[4:0];
        km2d_pkg::CFG_DIST_MODE:     distance_mode <= cfg_data[1:0];
        km2d_pkg::CFG_THRESHOLD:     error_threshold <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  logic [N_W-1:0] n_act;
  always_comb begin
    if (num_centroids == 5'd0) n_act = N_W'(1);
    else if (32'(num_centroids) > MAX_CENTROIDS) n_act = N_W'(MAX_CENTROIDS);
    else n_act = N_W'(num_centroids);
  end

  // stores
  logic signed [31:0]      cxs [MAX_CENTROIDS];
  logic signed [31:0]      cys [MAX_CENTROIDS];
  logic signed [SUM_W-1:0] sxs [MAX_CENTROIDS];
  logic signed [SUM_W-1:0] sys [MAX_CENTROIDS];
  logic [COUNT_BITS-1:0]   cnts [MAX_CENTROIDS];

  // working registers
  logic signed [31:0] px, py;        // point, new centroid position, or old position for the movement
  logic [IDX_W-1:0]   idx, best;
  logic signed [31:0] ax, ay;        // current centroid, or new position for the movement
  logic [32:0]        dx, dy;        // magnitudes
  logic [65:0]        sqx, sqy;
  logic [65:0]        key, best_key;
  logic [48:0]        dval;          // squared mode can exceed 48 bits
  logic [47:0]        total;
  logic [67:0]        rem;
  logic [32:0]        root;
  logic [5:0]         sq_k;
  logic               mul_sel;
  logic               is_end;

  // shared multiplier: one 33x33 square per cycle
  logic [32:0] mul_a;
  logic [65:0] mul_p;
  assign mul_a = mul_sel ? dy : dx;
  assign mul_p = mul_a * mul_a;

  // divider shared by x and y
  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] div_num, div_q;
  km2d_divider #(.NUM_W(SUM_W), .DEN_W(COUNT_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(cnts[idx]), .done(div_done), .quo(div_q)
  );
  logic div_y;

  logic signed [32:0] ex, ey;
  assign ex = 33'(px) - 33'(ax);
  assign ey = 33'(py) - 33'(ay);

  // square root step
  logic [67:0] rem_sh, trial;
  logic [1:0]  pair;
  assign pair   = key[2*sq_k +: 2];
  assign rem_sh = {rem[65:0], pair};
  assign trial  = {33'd0, root, 2'b01};

  logic [49:0] tot_sum;
  assign tot_sum = {2'b00, total} + {1'b0, dval};

  logic [COUNT_BITS-1:0] cmax;
  assign cmax = '1;

  logic [IDX_W-1:0] last_idx;
  assign last_idx = IDX_W'(n_act - 1'b1);

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
      div_start    <= 1'b0;
      for (int i = 0; i < MAX_CENTROIDS; i++) cnts[i] <= '0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            px <= in_ch.coord_x;
            py <= in_ch.coord_y;
            idx <= '0;
            best <= '0;
            total <= '0;
            case (in_ch.operation)
              km2d_pkg::OP_LOAD: begin
                if (32'(in_ch.centroid_slot) < MAX_CENTROIDS) begin
                  cxs[IDX_W'(in_ch.centroid_slot)] <= in_ch.coord_x;
                  cys[IDX_W'(in_ch.centroid_slot)] <= in_ch.coord_y;
                end
              end
              km2d_pkg::OP_CLASSIFY: begin
                is_end <= 1'b0;
                state  <= S_DIFF;
              end
              km2d_pkg::OP_END: begin
                is_end <= 1'b1;
                state  <= S_DIVX;
              end
              default: ;
            endcase
          end
        end
        S_DIFF: begin
          if (!is_end) begin
            ax <= cxs[idx];
            ay <= cys[idx];
          end
          state <= S_SQ;
          mul_sel <= 1'b0;
        end
        S_SQ: begin
          dx <= ex[32] ? 33'(-ex) : 33'(ex);
          dy <= ey[32] ? 33'(-ey) : 33'(ey);
          state <= S_SUM;
          mul_sel <= 1'b0;
          sq_k <= '0;
        end
        S_SUM: begin
          // square x then y through the one multiplier
          if (!sq_k[0]) begin
            sqx <= mul_p;
            mul_sel <= 1'b1;
            sq_k <= 6'd1;
          end else begin
            sqy <= mul_p;
            sq_k <= 6'd32;
            rem  <= '0;
            root <= '0;
            case (distance_mode)
              km2d_pkg::DM_MANHATTAN: begin
                key <= 66'(dx) + 66'(dy);
                dval <= 49'(34'(dx) + 34'(dy));
                state <= S_CMP;
              end
              km2d_pkg::DM_EUCLID: begin
                key <= sqx + mul_p;
                state <= S_SQRT;
              end
              km2d_pkg::DM_SQUARED: begin
                key <= sqx + mul_p;
                dval <= 49'((sqx + mul_p) >> 16);
                state <= S_CMP;
              end
              default: begin
                key <= '0;
                dval <= '0;
                state <= S_CMP;
              end
            endcase
          end
        end
        S_SQRT: begin
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[31:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[31:0], 1'b0};
          end
          if (sq_k == 6'd0) begin
            state <= S_CMP;
            key  <= 66'({root[31:0], (rem_sh >= trial)});
            dval <= 49'({root[31:0], (rem_sh >= trial)});
          end else begin
            sq_k <= sq_k - 1'b1;
          end
        end
        S_CMP: begin
          if (is_end) begin
            if (tot_sum[49:48] != 2'b00) total <= '1;
            else total <= tot_sum[47:0];
            cxs[idx] <= ax;
            cys[idx] <= ay;
            state <= (idx == last_idx) ? S_EOUT : S_DIVX;
            idx <= (idx == last_idx) ? '0 : idx + 1'b1;
          end else begin
            if (idx == '0 || key < best_key) begin
              best_key <= key;
              best <= idx;
            end
            if (idx == last_idx) state <= S_ACC;
            else begin
              idx <= idx + 1'b1;
              state <= S_DIFF;
            end
          end
        end
        S_ACC: begin
          if (cnts[best] < cmax) begin
            sxs[best] <= ((cnts[best] == '0) ? '0 : sxs[best]) + SUM_W'(px);
            sys[best] <= ((cnts[best] == '0) ? '0 : sys[best]) + SUM_W'(py);
            cnts[best] <= cnts[best] + 1'b1;
          end
          out_ch.valid          <= 1'b1;
          out_ch.nearest_index  <= 4'(best);
          out_ch.centroid_id    <= '0;
          out_ch.new_x          <= '0;
          out_ch.new_y          <= '0;
          out_ch.movement_total <= '0;
          out_ch.converged      <= 1'b0;
          out_ch.last           <= 1'b1;
          state <= S_POUT;
        end
        S_POUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_DIVX: begin
          if (cnts[idx] == '0) begin
            if (idx == last_idx) begin
              state <= S_EOUT;
              idx <= '0;
            end else idx <= idx + 1'b1;
          end else begin
            div_num   <= sxs[idx];
            div_start <= 1'b1;
            div_y     <= 1'b0;
            state     <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            if (!div_y) begin
              px <= 32'(div_q);
              div_num <= sys[idx];
              div_start <= 1'b1;
              div_y <= 1'b1;
            end else begin
              py <= 32'(div_q);
              state <= S_DIVY;
            end
          end
        end
        S_DIVY: begin
          // movement: old position in px/py path, new in ax/ay
          ax <= px;
          ay <= py;
          px <= cxs[idx];
          py <= cys[idx];
          state <= S_MOVE;
        end
        S_MOVE: state <= S_SQ;
        S_EOUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            if (out_ch.valid && out_ch.last) begin
              out_ch.valid <= 1'b0;
              idx <= '0;
              state <= S_CLR;
            end else begin
              out_ch.valid          <= 1'b1;
              out_ch.nearest_index  <= '0;
              out_ch.centroid_id    <= 4'(idx);
              out_ch.new_x          <= cxs[idx];
              out_ch.new_y          <= cys[idx];
              out_ch.movement_total <= total;
              out_ch.converged      <= (total < error_threshold);
              out_ch.last           <= (idx == last_idx);
              idx <= idx + 1'b1;
            end
          end
        end
        S_CLR: begin
          cnts[idx] <= '0;
          if (32'(idx) == MAX_CENTROIDS - 1) state <= S_IDLE;
          else idx <= idx + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/km2d_divider.sv =====
// Restoring signed divider, one quotient bit a cycle; truncates toward zero.
module km2d_divider #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        neg  <= num[NUM_W-1];
        q    <= num[NUM_W-1] ? (~num + 1'b1) : num;
        rem  <= '0;
        d    <= den;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? (~q + 1'b1) : q;
endmodule

// ===== bench/testbench.sv =====
module testbench;

  // ---------------------------------------------------------------
  // Clock, reset, channels
  // ---------------------------------------------------------------
  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [km2d_pkg::CFG_DATA_W-1:0] cfg_data;

  km2d_in_if  in_ch ();
  km2d_out_if out_ch ();

  kmeans_2d_iteration_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------
  // Word types
  // ---------------------------------------------------------------
  typedef struct {
    km2d_pkg::op_t op;
    logic [3:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
  } point_word_t;

  typedef struct {
    logic [3:0]  nearest;
    logic [3:0]  cid;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [47:0] moved;
    logic        conv;
    logic        last;
  } result_word_t;

  point_word_t  pending_words[$];
  result_word_t awaited_results[$];
  int mismatches;
  int cycles;
  bit calm;   // phase with no idling on either side

  // ---------------------------------------------------------------
  // Predictor state (own copy of the block)
  // ---------------------------------------------------------------
  localparam int NSLOT   = 16;
  localparam int CNT_MAX = (1 << 20) - 1;
  localparam logic [63:0] ERR_SAT = 64'hFFFF_FFFF_FFFF;

  logic [4:0]  k_reg;
  km2d_pkg::dmode_t mode_reg;
  logic [47:0] thresh_reg;
  longint      cent_x[NSLOT];
  longint      cent_y[NSLOT];
  longint      acc_x[NSLOT];
  longint      acc_y[NSLOT];
  int          members[NSLOT];

  function automatic logic [33:0] floor_root(input logic [65:0] v);
    logic [33:0] root;
    logic [33:0] trial;
    logic [67:0] sq;
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      trial = root | (34'd1 << b);
      sq = {34'd0, trial} * {34'd0, trial};
      if (sq <= {2'b00, v}) root = trial;
    end
    return root;
  endfunction

  // distance between two points: key orders the search, val is Q16.16
  task automatic span(input longint ax, input longint ay, input longint bx,
                      input longint by, output logic [65:0] key,
                      output logic [63:0] val);
    longint d;
    logic [65:0] dx;
    logic [65:0] dy;
    logic [65:0] sq;
    d = ax - bx;
    dx = (d < 0) ? 66'(-d) : 66'(d);
    d = ay - by;
    dy = (d < 0) ? 66'(-d) : 66'(d);
    sq = dx * dx + dy * dy;
    key = '0;
    val = '0;
    case (mode_reg)
      km2d_pkg::DM_MANHATTAN: begin
        val = 64'(dx + dy);
        key = dx + dy;
      end
      km2d_pkg::DM_EUCLID: begin
        val = 64'(floor_root(sq));
        key = 66'(val);
      end
      km2d_pkg::DM_SQUARED: begin
        key = sq;
        val = 64'(sq >> 16);
      end
      default: ;
    endcase
  endtask

  function automatic int in_use();
    if (k_reg == 0) return 1;
    if (k_reg > NSLOT) return NSLOT;
    return k_reg;
  endfunction

  task automatic predict_word(input point_word_t w);
    int n;
    int best;
    logic [65:0] bkey;
    logic [65:0] key;
    logic [63:0] val;
    logic [63:0] total;
    longint px;
    longint py;
    result_word_t r;
    n = in_use();
    px = longint'($signed(w.x));
    py = longint'($signed(w.y));
    case (w.op)
      km2d_pkg::OP_LOAD: begin
        cent_x[w.slot] = px;
        cent_y[w.slot] = py;
      end
      km2d_pkg::OP_CLASSIFY: begin
        best = 0;
        span(px, py, cent_x[0], cent_y[0], bkey, val);
        for (int i = 1; i < n; i++) begin
          span(px, py, cent_x[i], cent_y[i], key, val);
          if (key < bkey) begin   // strict: lowest index keeps ties
            bkey = key;
            best = i;
          end
        end
        if (members[best] < CNT_MAX) begin
          acc_x[best] += px;
          acc_y[best] += py;
          members[best]++;
        end
        r = '{nearest: 4'(best), cid: '0, nx: '0, ny: '0, moved: '0, conv: 1'b0,
              last: 1'b1};
        awaited_results.push_back(r);
      end
      km2d_pkg::OP_END: begin
        total = '0;
        for (int i = 0; i < n; i++) begin
          if (members[i] != 0) begin
            px = acc_x[i] / members[i];
            py = acc_y[i] / members[i];
            span(cent_x[i], cent_y[i], px, py, key, val);
            total = total + val;
            if (total > ERR_SAT) total = ERR_SAT;
            cent_x[i] = px;
            cent_y[i] = py;
          end
        end
        for (int i = 0; i < n; i++) begin
          r.nearest = '0;
          r.cid     = 4'(i);
          r.nx      = 32'(cent_x[i]);
          r.ny      = 32'(cent_y[i]);
          r.moved   = 48'(total);
          r.conv    = (48'(total) < thresh_reg);
          r.last    = (i == n - 1);
          awaited_results.push_back(r);
        end
        for (int i = 0; i < NSLOT; i++) begin
          acc_x[i] = 0;
          acc_y[i] = 0;
          members[i] = 0;
        end
      end
      default: ;   // unused operation: dropped
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // ---------------------------------------------------------------
  // Driver: feeds words from the pending queue
  // ---------------------------------------------------------------
  int send_gap;

  always @(posedge clk) begin
    point_word_t w;
    logic nv;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        w = '{op: km2d_pkg::op_t'(in_ch.operation), slot: in_ch.centroid_slot,
              x: in_ch.coord_x, y: in_ch.coord_y};
        predict_word(w);
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_ch.operation     <= w.op;
          in_ch.centroid_slot <= w.slot;
          in_ch.coord_x       <= w.x;
          in_ch.coord_y       <= w.y;
          nv = 1'b1;
          send_gap <= pick_gap();
        end
      end
      in_ch.valid <= nv;
    end
  end

  // ---------------------------------------------------------------
  // Monitor: random back-pressure, checks each result word
  // ---------------------------------------------------------------
  int recv_gap;

  always @(posedge clk) begin
    result_word_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result word idx=%0d id=%0d", $time,
                   out_ch.nearest_index, out_ch.centroid_id);
          mismatches++;
        end else begin
          e = awaited_results.pop_front();
          if (out_ch.nearest_index !== e.nearest) begin
            $display("%0t: nearest_index exp %0d got %0d", $time, e.nearest,
                     out_ch.nearest_index);
            mismatches++;
          end
          if (out_ch.centroid_id !== e.cid) begin
            $display("%0t: centroid_id exp %0d got %0d", $time, e.cid,
                     out_ch.centroid_id);
            mismatches++;
          end
          if (out_ch.new_x !== e.nx) begin
            $display("%0t: new_x exp %h got %h", $time, e.nx, out_ch.new_x);
            mismatches++;
          end
          if (out_ch.new_y !== e.ny) begin
            $display("%0t: new_y exp %h got %h", $time, e.ny, out_ch.new_y);
            mismatches++;
          end
          if (out_ch.movement_total !== e.moved) begin
            $display("%0t: movement_total exp %h got %h", $time, e.moved,
                     out_ch.movement_total);
            mismatches++;
          end
          if (out_ch.converged !== e.conv) begin
            $display("%0t: converged exp %b got %b", $time, e.conv,
                     out_ch.converged);
            mismatches++;
          end
          if (out_ch.last !== e.last) begin
            $display("%0t: last exp %b got %b", $time, e.last, out_ch.last);
            mismatches++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready) recv_gap <= pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  task automatic push(input km2d_pkg::op_t op, input logic [3:0] slot,
                      input logic [31:0] x, input logic [31:0] y);
    pending_words.push_back('{op: op, slot: slot, x: x, y: y});
  endtask

  // registers change only with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      km2d_pkg::CFG_NUM_CENTROIDS: k_reg = data[4:0];
      km2d_pkg::CFG_DIST_MODE:     mode_reg = km2d_pkg::dmode_t'(data[1:0]);
      km2d_pkg::CFG_THRESHOLD:     thresh_reg = data;
      default: ;
    endcase
  endtask

  // drained: nothing queued, in flight or awaited; then let loads settle.
  // Sampled at the falling edge so the driver's updates have landed.
  task automatic drain();
    while (pending_words.size() != 0 || in_ch.valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input logic [31:0] centre);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (r < 25) return $urandom();
    return centre + 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
  endfunction

  initial begin
    int sent;
    int k;
    int pts;
    logic [31:0] cx[NSLOT];
    logic [31:0] cy[NSLOT];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = km2d_pkg::OP_LOAD;
    in_ch.centroid_slot = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    calm = 1'b0;
    k_reg = 5'd1;
    mode_reg = km2d_pkg::DM_EUCLID;
    thresh_reg = '0;
    for (int i = 0; i < NSLOT; i++) begin
      cent_x[i] = 0;
      cent_y[i] = 0;
      acc_x[i] = 0;
      acc_y[i] = 0;
      members[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: every slot loaded so no unwritten centroid is read later
    for (int i = 0; i < NSLOT; i++)
      push(km2d_pkg::OP_LOAD, 4'(i), 32'(i) << 20, -(32'(i) << 20));
    // reset settings: one centroid, Euclidean
    push(km2d_pkg::OP_CLASSIFY, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    push(km2d_pkg::OP_NONE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(km2d_pkg::OP_END, 4'd0, '0, '0);
    drain();

    // zero centroids acts as one; Manhattan, highest threshold
    write_reg(km2d_pkg::CFG_NUM_CENTROIDS, 48'd0);
    write_reg(km2d_pkg::CFG_DIST_MODE, 48'(km2d_pkg::DM_MANHATTAN));
    write_reg(km2d_pkg::CFG_THRESHOLD, 48'hFFFF_FFFF_FFFF);
    push(km2d_pkg::OP_CLASSIFY, 4'd0, 32'h0001_0000, 32'h0002_0000);
    push(km2d_pkg::OP_END, 4'd0, '0, '0);
    drain();

    // above the maximum acts as sixteen; tie between equal centroids, empties
    write_reg(km2d_pkg::CFG_NUM_CENTROIDS, 48'd31);
    write_reg(km2d_pkg::CFG_DIST_MODE, 48'(km2d_pkg::DM_EUCLID));
    push(km2d_pkg::OP_LOAD, 4'd3, 32'h0050_0000, 32'h0050_0000);
    push(km2d_pkg::OP_LOAD, 4'd9, 32'h0050_0000, 32'h0050_0000);
    push(km2d_pkg::OP_CLASSIFY, 4'd0, 32'h0050_0000, 32'h0050_0000);
    push(km2d_pkg::OP_CLASSIFY, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    push(km2d_pkg::OP_END, 4'd0, '0, '0);
    drain();

    // squared distance with far moves: total saturates; lowest threshold
    write_reg(km2d_pkg::CFG_DIST_MODE, 48'(km2d_pkg::DM_SQUARED));
    write_reg(km2d_pkg::CFG_THRESHOLD, 48'd0);
    write_reg(km2d_pkg::CFG_NUM_CENTROIDS, 48'd2);
    push(km2d_pkg::OP_LOAD, 4'd0, 32'h8000_0000, 32'h8000_0000);
    push(km2d_pkg::OP_LOAD, 4'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push(km2d_pkg::OP_CLASSIFY, 4'd0, 32'h7FFF_0000, 32'h7FFF_0000);
    push(km2d_pkg::OP_CLASSIFY, 4'd0, 32'h8000_0000, 32'h8000_0000);
    push(km2d_pkg::OP_LOAD, 4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push(km2d_pkg::OP_LOAD, 4'd1, 32'h8000_0000, 32'h8000_0000);
    push(km2d_pkg::OP_END, 4'd0, '0, '0);
    drain();

    // zero distance: everything ties to centroid zero
    write_reg(km2d_pkg::CFG_DIST_MODE, 48'(km2d_pkg::DM_ZERO));
    push(km2d_pkg::OP_CLASSIFY, 4'd0, 32'h1234_5678, 32'h8765_4321);
    push(km2d_pkg::OP_END, 4'd0, '0, '0);
    drain();

    // random phases: load centroids, classify a cloud, close the iteration
    sent = 0;
    while (sent < 330) begin
      calm = ($urandom_range(0, 5) == 0);
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
      write_reg(km2d_pkg::CFG_NUM_CENTROIDS, 48'(k));
      write_reg(km2d_pkg::CFG_DIST_MODE, 48'($urandom_range(0, 3)));
      case ($urandom_range(0, 3))
        0: write_reg(km2d_pkg::CFG_THRESHOLD, 48'd0);
        1: write_reg(km2d_pkg::CFG_THRESHOLD, 48'hFFFF_FFFF_FFFF);
        default: write_reg(km2d_pkg::CFG_THRESHOLD, 48'($urandom_range(0, 32'h0100_0000)));
      endcase
      for (int i = 0; i < NSLOT; i++) begin
        cx[i] = $urandom();
        cy[i] = $urandom();
        if ($urandom_range(0, 1) != 0) begin
          push(km2d_pkg::OP_LOAD, 4'(i), cx[i], cy[i]);
          sent++;
        end
      end
      for (int it = 0; it < 2; it++) begin
        pts = $urandom_range(3, 14);
        for (int p = 0; p < pts; p++) begin
          k = $urandom_range(0, NSLOT - 1);
          if ($urandom_range(0, 19) == 0) begin
            push(km2d_pkg::OP_NONE, 4'($urandom()), $urandom(), $urandom());
          end else if ($urandom_range(0, 19) == 0) begin
            push(km2d_pkg::OP_LOAD, 4'($urandom()), $urandom(), $urandom());
            sent++;
          end else begin
            push(km2d_pkg::OP_CLASSIFY, 4'($urandom()), rand_coord(cx[k]),
                 rand_coord(cy[k]));
            sent++;
          end
        end
        push(km2d_pkg::OP_END, 4'($urandom()), $urandom(), $urandom());
        sent++;
      end
      drain();
    end
    calm = 1'b0;

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
